// ===== rtl/median_of_two_sorted_arrays_assert.svh =====
// Assertion macros for the median block's RTL; only motsa_merge includes them.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef MEDIAN_OF_TWO_SORTED_ARRAYS_ASSERT_SVH
`define MEDIAN_OF_TWO_SORTED_ARRAYS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MOTSA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the following cycle
`define MOTSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/motsa_pkg.sv =====
// Package for the median-of-two-sorted-lists block: transaction structs,
// action codes and sizing constants. No dependencies.
package motsa_pkg;

	localparam int DEFAULT_LIST_DEPTH = 1024;
	localparam int VALUE_W            = 32;
	localparam int RESULT_W           = VALUE_W + 1;
	localparam int ACTION_W           = 2;

	localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_COMPUTE     = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] median_doubled;
		logic                       empty_error;
		logic                       overflow_seen;
	} res_t;

endpackage

// ===== rtl/motsa_list_mem.sv =====
// One list store: single write port, single read port, registered read data.
// Depends on motsa_pkg for the element width.
module motsa_list_mem #(
	parameter int DEPTH = motsa_pkg::DEFAULT_LIST_DEPTH,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [ADDR_W-1:0]                   wr_addr,
	input  logic signed [motsa_pkg::VALUE_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]                   rd_addr,
	output logic signed [motsa_pkg::VALUE_W-1:0] rd_data
);

	logic signed [motsa_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/motsa_merge.sv =====
// Merge walker: steps both list stores head by head, one merged element per
// cycle, and forms twice the median. Depends on motsa_pkg and the assert header.
`include "median_of_two_sorted_arrays_assert.svh"

module motsa_merge #(
	parameter int LIST_DEPTH = motsa_pkg::DEFAULT_LIST_DEPTH,
	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic [CNT_W-1:0]                     n1,
	input  logic [CNT_W-1:0]                     n2,
	input  logic                                 dropped,
	output logic                                 busy,
	output logic [ADDR_W-1:0]                    rd_addr1,
	output logic [ADDR_W-1:0]                    rd_addr2,
	input  logic signed [motsa_pkg::VALUE_W-1:0] rd_data1,
	input  logic signed [motsa_pkg::VALUE_W-1:0] rd_data2,
	input  logic                                 out_free,
	output logic                                 done,
	output motsa_pkg::res_t                      result
);

	localparam int TOT_W = CNT_W + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_t;

	state_t state_q;
	logic [CNT_W-1:0] n1_q, n2_q, a_q, b_q;
	logic [TOT_W-1:0] steps_q;
	logic             odd_q, empty_q, dropped_q;
	logic signed [motsa_pkg::VALUE_W-1:0] prev_q, last_q;

	logic [TOT_W-1:0] total;
	logic             take1;
	logic [CNT_W-1:0] a_nxt, b_nxt;
	logic signed [motsa_pkg::VALUE_W-1:0] pick;
	logic signed [motsa_pkg::RESULT_W-1:0] sum;

	assign total = {1'b0, n1} + {1'b0, n2};

	// first list wins while it has elements and either the second list is exhausted or its head is strictly smaller
	assign take1 = (a_q < n1_q) && ((b_q >= n2_q) || (rd_data1 < rd_data2));
	assign pick  = take1 ? rd_data1 : rd_data2;
	assign a_nxt = a_q + CNT_W'(take1);
	assign b_nxt = b_q + CNT_W'(!take1);

	// read the post-step heads so that they land on the next cycle
	always_comb begin
		if (state_q == ST_WALK) begin
			rd_addr1 = a_nxt[ADDR_W-1:0];
			rd_addr2 = b_nxt[ADDR_W-1:0];
		end else begin
			rd_addr1 = '0;
			rd_addr2 = '0;
		end
	end

	assign sum = odd_q ? {last_q, 1'b0}
	                   : (motsa_pkg::RESULT_W'(prev_q) + motsa_pkg::RESULT_W'(last_q));

	always_comb begin
		result.median_doubled = empty_q ? '0 : sum;
		result.empty_error    = empty_q;
		result.overflow_seen  = dropped_q;
	end

	assign done = (state_q == ST_FINISH) && out_free;
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n1_q      <= '0;
			n2_q      <= '0;
			a_q       <= '0;
			b_q       <= '0;
			steps_q   <= '0;
			odd_q     <= 1'b0;
			empty_q   <= 1'b0;
			dropped_q <= 1'b0;
			prev_q    <= '0;
			last_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						n1_q      <= n1;
						n2_q      <= n2;
						a_q       <= '0;
						b_q       <= '0;
						steps_q   <= (total >> 1) + TOT_W'(1);
						odd_q     <= total[0];
						empty_q   <= (total == '0);
						dropped_q <= dropped;
						prev_q    <= '0;
						last_q    <= '0;
						state_q   <= (total == '0) ? ST_FINISH : ST_WALK;
					end
				end
				ST_WALK: begin
					a_q     <= a_nxt;
					b_q     <= b_nxt;
					prev_q  <= last_q;
					last_q  <= pick;
					steps_q <= steps_q - TOT_W'(1);
					if (steps_q == TOT_W'(1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MOTSA_ASSERT_SAME(a_walk_in_range, state_q == ST_WALK, (a_q <= n1_q) && (b_q <= n2_q), "merge pointer ran past its list")
	`MOTSA_ASSERT_SAME(a_step_has_head, state_q == ST_WALK, (a_q < n1_q) || (b_q < n2_q), "merge step with both lists exhausted")
	`MOTSA_ASSERT_SAME(a_go_when_idle, go, state_q == ST_IDLE, "compute started while walker busy")
	`MOTSA_ASSERT_NEXT(a_done_returns_idle, done, state_q == ST_IDLE, "walker did not return to idle after result")

endmodule

// ===== rtl/median_of_two_sorted_arrays.sv =====
// Top level of the median-of-two-sorted-lists block: load counters, the two
// list stores, the merge walker and the result register. Depends on motsa_pkg,
// motsa_list_mem and motsa_merge.
//
//  channel | valid     | stall     | payload            | moves
//  --------+-----------+-----------+--------------------+------------------------
//  cmd     | cmd_valid | cmd_stall | cmd (cmd_t)        | load or compute action
//  res     | res_valid | res_stall | res (res_t)        | doubled median + flags
//
// Load transactions are taken one per cycle while no compute is running; a
// compute holds cmd_stall through the merge walk, which takes one element per
// cycle from the two single-read-port stores, and through the finish state,
// which lasts until the result register is free.
// The result waits in an output register; a stalled result holds the next
// compute in its finish state, and cmd_stall with it; loads flow until it is accepted.
// Reset clears the counts and drop flag; store contents are not cleared.
module median_of_two_sorted_arrays #(
	parameter int LIST_DEPTH = motsa_pkg::DEFAULT_LIST_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  motsa_pkg::cmd_t   cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output motsa_pkg::res_t   res
);

	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

	logic [CNT_W-1:0] cnt1_q, cnt2_q;
	logic             drop_q;
	logic             res_valid_q;
	motsa_pkg::res_t  res_q;

	logic accept, load1, load2, compute, room1, room2, wr1, wr2;
	logic busy, done, out_free;
	logic [ADDR_W-1:0] rd_addr1, rd_addr2;
	logic signed [motsa_pkg::VALUE_W-1:0] rd_data1, rd_data2;
	motsa_pkg::res_t merge_res;

	assign cmd_stall = busy;
	assign accept    = cmd_valid && !cmd_stall;
	assign load1     = accept && (cmd.action == motsa_pkg::ACT_LOAD_FIRST);
	assign load2     = accept && (cmd.action == motsa_pkg::ACT_LOAD_SECOND);
	assign compute   = accept && (cmd.action == motsa_pkg::ACT_COMPUTE);
	assign room1     = cnt1_q < CNT_W'(LIST_DEPTH);
	assign room2     = cnt2_q < CNT_W'(LIST_DEPTH);
	assign wr1       = load1 && room1;
	assign wr2       = load2 && room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
			drop_q <= 1'b0;
		end else begin
			priority if (compute) begin
				// walker has latched counts and flag
				cnt1_q <= '0;
				cnt2_q <= '0;
				drop_q <= 1'b0;
			end else begin
				if (wr1) begin
					cnt1_q <= cnt1_q + CNT_W'(1);
				end
				if (wr2) begin
					cnt2_q <= cnt2_q + CNT_W'(1);
				end
				if ((load1 && !room1) || (load2 && !room2)) begin
					drop_q <= 1'b1;
				end
			end
		end
	end

	motsa_list_mem #(.DEPTH(LIST_DEPTH)) u_mem1 (
		.clk     (clk),
		.wr_en   (wr1),
		.wr_addr (cnt1_q[ADDR_W-1:0]),
		.wr_data (cmd.value),
		.rd_addr (rd_addr1),
		.rd_data (rd_data1)
	);

	motsa_list_mem #(.DEPTH(LIST_DEPTH)) u_mem2 (
		.clk     (clk),
		.wr_en   (wr2),
		.wr_addr (cnt2_q[ADDR_W-1:0]),
		.wr_data (cmd.value),
		.rd_addr (rd_addr2),
		.rd_data (rd_data2)
	);

	assign out_free = !res_valid_q || !res_stall;

	motsa_merge #(.LIST_DEPTH(LIST_DEPTH)) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (compute),
		.n1       (cnt1_q),
		.n2       (cnt2_q),
		.dropped  (drop_q),
		.busy     (busy),
		.rd_addr1 (rd_addr1),
		.rd_addr2 (rd_addr2),
		.rd_data1 (rd_data1),
		.rd_data2 (rd_data2),
		.out_free (out_free),
		.done     (done),
		.result   (merge_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			priority if (done) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= merge_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
